>>> sv/tuner_pll_divider_calc_assert.svh
// Assertion macros for the divider calculation RTL.
// Depends on nothing; included by the module that carries assertions.
`ifndef TUNER_PLL_DIVIDER_CALC_ASSERT_SVH
`define TUNER_PLL_DIVIDER_CALC_ASSERT_SVH

// Implication checked in the same cycle.
`define TPDC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Implication checked in the following cycle.
`define TPDC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tpdc_pkg.sv
// Package for the PLL divider calculation: widths, register map, reset values,
// divider control types and the integer word packing function.
// Depends on nothing.
package tpdc_pkg;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 64;

	localparam int REF_W  = 27;
	localparam int VLIM_W = 33;
	localparam int PWR_W  = 2;
	localparam int TGT_W  = 32;
	localparam int FINE_W = 2;
	localparam int DIVC_W = 3;
	localparam int WORD_W = 8;
	localparam int SDM_W  = 16;
	localparam int FRAC_W = 32;
	localparam int RK_W   = 17;
	localparam int DVS_W  = 28;
	localparam int STEP_W = 6;

	localparam logic [1:0] REG_REF  = 2'd0;
	localparam logic [1:0] REG_VMIN = 2'd1;
	localparam logic [1:0] REG_VMAX = 2'd2;
	localparam logic [1:0] REG_PWR  = 2'd3;

	localparam logic [REF_W-1:0]  REF_RST  = 27'd28800000;
	localparam logic [VLIM_W-1:0] VMIN_RST = 33'd1770000000;
	localparam logic [VLIM_W-1:0] VMAX_RST = 33'd3900000000;
	localparam logic [PWR_W-1:0]  PWR_RST  = 2'd2;

	localparam logic [REF_W-1:0]  REF_HALVE_ABOVE = 27'd24000000;
	localparam logic [DVS_W-1:0]  KHZ             = 28'd1000;
	localparam logic [SDM_W-1:0]  SDM_FULL        = 16'h8000;
	localparam logic signed [9:0] NI_OFFSET       = 10'sd13;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// Packs N + (S << 6) from q - 13, with N rounded toward zero.
	function automatic logic [WORD_W-1:0] pack_int_word(input logic [7:0] q8);
		logic signed [9:0] d;
		logic        [9:0] mag;
		logic signed [9:0] ni;
		logic signed [9:0] si;
		d = $signed({2'b00, q8}) - NI_OFFSET;
		if (d < 0) begin
			mag = 10'(-d);
			ni  = -$signed(mag >> 2);
		end else begin
			ni = d >>> 2;
		end
		si = d - (ni <<< 2);
		return ni[7:0] + {si[1:0], 6'b000000};
	endfunction

endpackage

>>> sv/tpdc_req_if.sv
// Request channel: target frequency and VCO fine-tune reading.
// Depends on tpdc_pkg.
interface tpdc_req_if;
	logic                        valid;
	logic                        ready;
	logic [tpdc_pkg::TGT_W-1:0]  target_freq_hz;
	logic [tpdc_pkg::FINE_W-1:0] vco_fine_tune;

	modport source(output valid, output target_freq_hz, output vco_fine_tune, input ready);
	modport sink(input valid, input target_freq_hz, input vco_fine_tune, output ready);
endinterface

>>> sv/tpdc_rsp_if.sv
// Result channel: divider settings for one request.
// Depends on tpdc_pkg.
interface tpdc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        bad_request;
	logic                        ref_halved;
	logic [tpdc_pkg::DIVC_W-1:0] out_div_code;
	logic [tpdc_pkg::WORD_W-1:0] int_div_word;
	logic                        frac_disabled;
	logic [tpdc_pkg::SDM_W-1:0]  sdm_word;

	modport source(output valid, output bad_request, output ref_halved, output out_div_code,
		output int_div_word, output frac_disabled, output sdm_word, input ready);
	modport sink(input valid, input bad_request, input ref_halved, input out_div_code,
		input int_div_word, input frac_disabled, input sdm_word, output ready);
endinterface

>>> sv/tuner_pll_divider_calc.sv
// Top level of the fractional-N PLL divider calculation: sequencer, datapath,
// configuration registers. Depends on tpdc_pkg, tpdc_req_if, tpdc_rsp_if, tpdc_div.
//
//   Channel  Dir  Handshake            Beat contents
//   req      in   valid/ready          target_freq_hz, vco_fine_tune
//   rsp      out  valid/ready          bad_request .. sdm_word
//   apb      in   psel/penable/pready  64-bit register write or read
//
// The divider yields one quotient bit per cycle and serves three divisions in turn.
// A zero target skips all divisions. A new request is taken once the sequencer is idle,
// even while the previous result still waits on rsp. Reset is asynchronous, active low,
// and restores the register defaults; no clearing pass is needed.
`include "tuner_pll_divider_calc_assert.svh"

module tuner_pll_divider_calc #(
	parameter int DIV_TRIES       = 5,
	parameter int SDM_COUNT_LIMIT = 32768
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tpdc_req_if.sink                    req,
	tpdc_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpdc_pkg::CFG_AW-1:0] paddr,
	input  logic [tpdc_pkg::CFG_DW-1:0] pwdata,
	output logic [tpdc_pkg::CFG_DW-1:0] prdata,
	output logic                        pready
);
	import tpdc_pkg::*;

	localparam int VW = TGT_W + DIV_TRIES;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SEARCH = 4'd1;
	localparam logic [3:0] ST_DIVQ   = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_SUB    = 4'd4;
	localparam logic [3:0] ST_DIVR   = 4'd5;
	localparam logic [3:0] ST_DIVK   = 4'd6;
	localparam logic [3:0] ST_SDM    = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]        state_q;
	logic              start_q;
	logic              out_valid_q;

	logic [REF_W-1:0]  ref_cfg_q;
	logic [VLIM_W-1:0] vmin_q;
	logic [VLIM_W-1:0] vmax_q;
	logic [PWR_W-1:0]  pwr_q;

	logic [TGT_W-1:0]  target_q;
	logic [FINE_W-1:0] fine_q;
	logic              bad_q;
	logic              halved_q;
	logic [REF_W-1:0]  ref_q;
	logic [DVS_W-1:0]  two_ref_q;
	logic [2:0]        idx_q;
	logic [DIVC_W-1:0] div_q;
	logic [VW-1:0]     vco_q;
	logic [7:0]        q8_q;
	logic [35:0]       prod_q;
	logic [VW-1:0]     rem_q;
	logic [FRAC_W-1:0] frac_q;
	logic              frac_zero_q;
	logic [RK_W:0]     two_rk_q;
	logic [3:0]        k_q;
	logic [SDM_W-1:0]  sdm_q;

	logic              o_bad_q;
	logic              o_halved_q;
	logic [DIVC_W-1:0] o_div_q;
	logic [WORD_W-1:0] o_word_q;
	logic              o_fdis_q;
	logic [SDM_W-1:0]  o_sdm_q;

	logic              acc;
	logic              cfg_wr;
	logic              ref_half;
	logic [REF_W-1:0]  ref_eff;
	logic [VW-1:0]     vco_try;
	logic              hit;
	logic              last_try;
	logic [DIVC_W-1:0] div_sel;
	logic [DIVC_W-1:0] div_nudged;
	logic [RK_W:0]     step_v;
	logic              take;
	logic [16:0]       count_v;
	logic              lim_hit;
	logic              out_load;

	div_ctl_t          div_ctl;
	div_sts_t          div_sts;
	logic [VW-1:0]     div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic [VW-1:0]     div_quot;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;

	assign ref_half = ref_cfg_q > REF_HALVE_ABOVE;
	always_comb begin
		ref_eff = ref_half ? (ref_cfg_q >> 1) : ref_cfg_q;
		if (ref_eff == '0) begin
			ref_eff = REF_W'(1);
		end
	end

	assign vco_try  = VW'(target_q) << ({1'b0, idx_q} + 4'd1);
	assign hit      = (vco_try >= VW'(vmin_q)) && (vco_try <= VW'(vmax_q));
	assign last_try = idx_q == 3'(DIV_TRIES - 1);
	assign div_sel  = hit ? idx_q : 3'(DIV_TRIES);

	always_comb begin
		if (fine_q > pwr_q) begin
			div_nudged = div_sel - 3'd1;
		end else if (fine_q < pwr_q) begin
			div_nudged = div_sel + 3'd1;
		end else begin
			div_nudged = div_sel;
		end
	end

	assign step_v   = two_rk_q >> k_q;
	assign take     = frac_q > FRAC_W'(step_v);
	assign count_v  = 17'(1) << k_q;
	assign lim_hit  = count_v >= 17'(SDM_COUNT_LIMIT);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		div_ctl.start = start_q;
		unique case (state_q)
			ST_DIVQ: begin
				div_dividend  = vco_q;
				div_divisor   = two_ref_q;
				div_ctl.steps = STEP_W'(VW);
			end
			ST_DIVR: begin
				div_dividend  = rem_q;
				div_divisor   = KHZ;
				div_ctl.steps = STEP_W'(VW);
			end
			ST_DIVK: begin
				div_dividend  = VW'(ref_q) << (VW - REF_W);
				div_divisor   = KHZ;
				div_ctl.steps = STEP_W'(REF_W);
			end
			default: begin
				div_dividend  = '0;
				div_divisor   = '0;
				div_ctl.steps = '0;
			end
		endcase
	end

	tpdc_div #(
		.DW(VW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.sts     (div_sts),
		.quot    (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= (req.target_freq_hz == '0) ? ST_DONE : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit || last_try) begin
						state_q <= ST_DIVQ;
						start_q <= 1'b1;
					end
				end
				ST_DIVQ: begin
					if (div_sts.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					state_q <= ST_DIVR;
					start_q <= 1'b1;
				end
				ST_DIVR: begin
					if (div_sts.done) begin
						state_q <= ST_DIVK;
						start_q <= 1'b1;
					end
				end
				ST_DIVK: begin
					if (div_sts.done) begin
						state_q <= ST_SDM;
					end
				end
				ST_SDM: begin
					if ((frac_q <= FRAC_W'(1)) || lim_hit) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					target_q  <= req.target_freq_hz;
					fine_q    <= req.vco_fine_tune;
					bad_q     <= req.target_freq_hz == '0;
					halved_q  <= ref_half;
					ref_q     <= ref_eff;
					two_ref_q <= {ref_eff, 1'b0};
					idx_q     <= '0;
				end
			end
			ST_SEARCH: begin
				if (hit || last_try) begin
					vco_q <= vco_try;
					div_q <= div_nudged;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			ST_DIVQ: begin
				if (div_sts.done) begin
					q8_q <= div_quot[7:0];
				end
			end
			ST_MUL: begin
				prod_q <= two_ref_q * q8_q;
			end
			ST_SUB: begin
				rem_q <= vco_q - VW'(prod_q);
			end
			ST_DIVR: begin
				if (div_sts.done) begin
					frac_q      <= div_quot[FRAC_W-1:0];
					frac_zero_q <= div_quot == '0;
				end
			end
			ST_DIVK: begin
				if (div_sts.done) begin
					two_rk_q <= {div_quot[RK_W-1:0], 1'b0};
					k_q      <= 4'd1;
					sdm_q    <= '0;
				end
			end
			ST_SDM: begin
				if (frac_q > FRAC_W'(1)) begin
					if (take) begin
						sdm_q  <= sdm_q + (SDM_FULL >> (k_q - 4'd1));
						frac_q <= frac_q - FRAC_W'(step_v);
					end
					if (!lim_hit) begin
						k_q <= k_q + 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_bad_q    <= bad_q;
			o_halved_q <= bad_q ? 1'b0 : halved_q;
			o_div_q    <= bad_q ? '0 : div_q;
			o_word_q   <= bad_q ? '0 : pack_int_word(q8_q);
			o_fdis_q   <= bad_q ? 1'b0 : frac_zero_q;
			o_sdm_q    <= bad_q ? '0 : sdm_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.bad_request   = o_bad_q;
	assign rsp.ref_halved    = o_halved_q;
	assign rsp.out_div_code  = o_div_q;
	assign rsp.int_div_word  = o_word_q;
	assign rsp.frac_disabled = o_fdis_q;
	assign rsp.sdm_word      = o_sdm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cfg_q <= REF_RST;
			vmin_q    <= VMIN_RST;
			vmax_q    <= VMAX_RST;
			pwr_q     <= PWR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_REF:  ref_cfg_q <= pwdata[REF_W-1:0];
				REG_VMIN: vmin_q    <= pwdata[VLIM_W-1:0];
				REG_VMAX: vmax_q    <= pwdata[VLIM_W-1:0];
				REG_PWR:  pwr_q     <= pwdata[PWR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_REF:  prdata = CFG_DW'(ref_cfg_q);
			REG_VMIN: prdata = CFG_DW'(vmin_q);
			REG_VMAX: prdata = CFG_DW'(vmax_q);
			REG_PWR:  prdata = CFG_DW'(pwr_q);
			default:  prdata = '0;
		endcase
	end

	`TPDC_ASSERT_NOW(a_div_busy_state, clk, arst_n, div_sts.busy, (state_q == ST_DIVQ) || (state_q == ST_DIVR) || (state_q == ST_DIVK), "divider busy outside a divide state")
	`TPDC_ASSERT_NEXT(a_accept_search, clk, arst_n, acc && (req.target_freq_hz != '0), state_q == ST_SEARCH, "nonzero target did not start the divider search")
	`TPDC_ASSERT_NOW(a_rem_nonneg, clk, arst_n, state_q == ST_SUB, vco_q >= prod_q, "integer part product exceeds the VCO value")
	`TPDC_ASSERT_NOW(a_sdm_k_range, clk, arst_n, state_q == ST_SDM, (k_q != 4'd0) && (k_q <= 4'd15), "expansion step index out of range")

endmodule

>>> sv/tpdc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on tpdc_pkg; the dividend is presented left-aligned.
module tpdc_div #(
	parameter int DW = 37
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpdc_pkg::div_ctl_t         ctl,
	input  logic [DW-1:0]              dividend,
	input  logic [tpdc_pkg::DVS_W-1:0] divisor,
	output tpdc_pkg::div_sts_t         sts,
	output logic [DW-1:0]              quot
);
	import tpdc_pkg::*;

	logic [DW-1:0]     dq_q;
	logic [DVS_W-1:0]  r_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;
	logic [DVS_W-1:0]  r_nxt;

	assign trial = {r_q, dq_q[DW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};
	assign r_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q <= dividend;
			r_q  <= '0;
		end else if (busy_q) begin
			dq_q <= {dq_q[DW-2:0], ge};
			r_q  <= r_nxt;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = dq_q;

endmodule

>>> tb/tb_tuner_pll_divider_calc.sv
`timescale 1ns / 1ps
// Testbench for tuner_pll_divider_calc: a directed table, then random requests under several
// register settings, every result beat checked against a divider predictor held in the bench.
// Depends on tpdc_pkg, tpdc_req_if, tpdc_rsp_if and the block itself.
module tb_tuner_pll_divider_calc;
	import tpdc_pkg::*;

	localparam int DIV_TRIES       = 5;
	localparam int SDM_COUNT_LIMIT = 32768;
	localparam int PHASE_ITEMS     = 250;
	localparam int N_PHASES        = 7;
	localparam int HOLD_CYCLES     = 600;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int END_CYCLES      = 200;
	localparam int N_DIR           = 22;

	typedef struct packed {
		logic              bad_request;
		logic              ref_halved;
		logic [DIVC_W-1:0] out_div_code;
		logic [WORD_W-1:0] int_div_word;
		logic              frac_disabled;
		logic [SDM_W-1:0]  sdm_word;
	} pll_setting_t;

	typedef struct packed {
		logic [TGT_W-1:0]  target;
		logic [FINE_W-1:0] fine;
		logic              typed;
		pll_setting_t      want;
	} dir_row_t;

	typedef struct packed {
		logic [REF_W-1:0]  ref_hz;
		logic [VLIM_W-1:0] vmin;
		logic [VLIM_W-1:0] vmax;
		logic [PWR_W-1:0]  pwr;
	} reg_setting_t;

	localparam pll_setting_t ZERO_TARGET = '{1'b1, 1'b0, 3'd0, 8'd0, 1'b0, 16'd0};

	// A target of 1 Hz under the reset registers gives q = 0, so the word wraps to 189.
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{32'd0, 2'd0, 1'b1, ZERO_TARGET},
		'{32'd0, 2'd1, 1'b1, ZERO_TARGET},
		'{32'd0, 2'd2, 1'b1, ZERO_TARGET},
		'{32'd0, 2'd3, 1'b1, ZERO_TARGET},
		'{32'd1, 2'd2, 1'b1, '{1'b0, 1'b1, 3'd5, 8'd189, 1'b1, 16'd0}},
		'{32'd1, 2'd3, 1'b1, '{1'b0, 1'b1, 3'd4, 8'd189, 1'b1, 16'd0}},
		'{32'd1, 2'd0, 1'b1, '{1'b0, 1'b1, 3'd6, 8'd189, 1'b1, 16'd0}},
		'{32'd1, 2'd1, 1'b1, '{1'b0, 1'b1, 3'd6, 8'd189, 1'b1, 16'd0}},
		'{32'hFFFFFFFF, 2'd0, 1'b0, '0},
		'{32'hFFFFFFFF, 2'd3, 1'b0, '0},
		'{32'd885000000, 2'd2, 1'b0, '0},
		'{32'd884999999, 2'd2, 1'b0, '0},
		'{32'd1950000000, 2'd2, 1'b0, '0},
		'{32'd1950000001, 2'd2, 1'b0, '0},
		'{32'd1000000000, 2'd3, 1'b0, '0},
		'{32'd720000000, 2'd1, 1'b0, '0},
		'{32'd720000100, 2'd2, 1'b0, '0},
		'{32'd720000250, 2'd2, 1'b0, '0},
		'{32'd55312500, 2'd2, 1'b0, '0},
		'{32'h80000000, 2'd2, 1'b0, '0},
		'{32'h55555555, 2'd1, 1'b0, '0},
		'{32'h2AAAAAAA, 2'd0, 1'b0, '0}
	};

	// The last setting is drawn at random when its phase begins.
	localparam reg_setting_t PHASE_REGS [N_PHASES-1] = '{
		'{27'd28800000, 33'd1770000000, 33'd3900000000, 2'd2},
		'{27'd24000000, 33'd1770000000, 33'd3900000000, 2'd0},
		'{27'd24000001, 33'd1500000000, 33'd3000000000, 2'd3},
		'{27'd0, 33'd0, 33'h1FFFFFFFF, 2'd1},
		'{27'd100000000, 33'h1FFFFFFFF, 33'd0, 2'd0},
		'{27'h7FFFFFF, 33'd2000000000, 33'd2000000000, 2'd3}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [CFG_AW-1:0]  paddr;
	logic [CFG_DW-1:0]  pwdata;
	logic [CFG_DW-1:0]  prdata;
	logic               pready;

	tpdc_req_if req_ch ();
	tpdc_rsp_if rsp_ch ();

	tuner_pll_divider_calc #(
		.DIV_TRIES(DIV_TRIES),
		.SDM_COUNT_LIMIT(SDM_COUNT_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	logic [REF_W-1:0]  cfg_ref  = REF_RST;
	logic [VLIM_W-1:0] cfg_vmin = VMIN_RST;
	logic [VLIM_W-1:0] cfg_vmax = VMAX_RST;
	logic [PWR_W-1:0]  cfg_pwr  = PWR_RST;

	pll_setting_t pending_settings [$];
	pll_setting_t oldest;
	int mismatches    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int zero_results  = 0;
	int settings_used = 1;
	int stall_cycles  = 0;
	int send_idle     = 0;
	int rcv_idle      = 0;
	bit hold_pending  = 1'b0;

	function automatic logic [31:0] effective_ref();
		logic [31:0] r;
		r = 32'(cfg_ref);
		if (r > 32'(REF_HALVE_ABOVE))
			r = r >> 1;
		if (r == 0)
			r = 1;
		return r;
	endfunction

	function automatic pll_setting_t calc_divider_setting(input logic [TGT_W-1:0] target,
			input logic [FINE_W-1:0] fine);
		pll_setting_t s;
		logic [31:0]  ref_hz;
		logic [31:0]  div;
		logic [31:0]  frac;
		logic [31:0]  step;
		logic [31:0]  cnt;
		logic [63:0]  vco;
		logic [63:0]  two_ref;
		logic [63:0]  rem;
		logic [7:0]   q8;
		logic [15:0]  sdm;
		bit           found;
		bit           last_step;
		int           d;
		int           ni;
		int           si;
		int           word;
		s = '0;
		if (target == 0) begin
			s.bad_request = 1'b1;
			return s;
		end
		s.ref_halved = (32'(cfg_ref) > 32'(REF_HALVE_ABOVE));
		ref_hz = effective_ref();
		vco = 0;
		div = DIV_TRIES;
		found = 1'b0;
		for (int i = 0; i < DIV_TRIES; i++) begin
			if (!found) begin
				vco = 64'(target) << (i + 1);
				if (vco >= 64'(cfg_vmin) && vco <= 64'(cfg_vmax)) begin
					found = 1'b1;
					div = i;
				end
			end
		end
		if (fine > cfg_pwr)
			div = div - 1;
		else if (fine < cfg_pwr)
			div = div + 1;
		s.out_div_code = div[DIVC_W-1:0];
		two_ref = 2 * 64'(ref_hz);
		q8 = 8'(vco / two_ref);
		rem = vco - two_ref * 64'(q8);
		frac = 32'(rem / 64'(KHZ));
		d = int'(q8) - int'(NI_OFFSET);
		ni = d / 4;
		si = d - 4 * ni;
		word = ni + (si <<< 6);
		s.int_div_word = word[WORD_W-1:0];
		sdm = 0;
		cnt = 2;
		last_step = 1'b0;
		while (frac > 1 && !last_step) begin
			step = 2 * (ref_hz / 32'(KHZ)) / cnt;
			if (frac > step) begin
				sdm = sdm + 16'(32'(SDM_FULL) / (cnt >> 1));
				frac = frac - step;
			end
			if (cnt >= SDM_COUNT_LIMIT)
				last_step = 1'b1;
			else
				cnt = cnt << 1;
		end
		s.frac_disabled = (rem / 64'(KHZ) == 0);
		s.sdm_word = sdm;
		return s;
	endfunction

	// Mostly targets that land in the VCO window, on its edges or on whole reference multiples.
	function automatic logic [TGT_W-1:0] pick_target();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] base;
		int          sh;
		sh = $urandom_range(1, DIV_TRIES + 1);
		lo = 64'(cfg_vmin) >> sh;
		hi = 64'(cfg_vmax) >> sh;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(0, 300);
			4, 5, 6: begin
				if (lo <= hi)
					return $urandom_range(32'(hi), 32'(lo));
			end
			7: return ($urandom_range(0, 1) ? 32'(lo) : 32'(hi)) + $urandom_range(0, 2) - 32'd1;
			8, 9: begin
				base = (2 * 64'(effective_ref()) * $urandom_range(1, 300)) >> sh;
				return 32'(base) + $urandom_range(0, 2) * 32'd500;
			end
			default: ;
		endcase
		return $urandom;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			if (mismatches < 30)
				$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_item(input logic [TGT_W-1:0] t, input logic [FINE_W-1:0] f,
			input pll_setting_t want);
		while ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.target_freq_hz <= t;
		req_ch.vco_fine_tune <= f;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		pending_settings.push_back(want);
		items_sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_settings.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_access(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
		logic [CFG_DW-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== value) begin
			$error("register %0d: expected %0h, got %0h", idx, value, got);
			mismatches++;
		end
	endtask

	task automatic program_registers(input reg_setting_t rs);
		reg_access(REG_REF, CFG_DW'(rs.ref_hz));
		reg_access(REG_VMIN, CFG_DW'(rs.vmin));
		reg_access(REG_VMAX, CFG_DW'(rs.vmax));
		reg_access(REG_PWR, CFG_DW'(rs.pwr));
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_ref = rs.ref_hz;
		cfg_vmin = rs.vmin;
		cfg_vmax = rs.vmax;
		cfg_pwr = rs.pwr;
		settings_used++;
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				repeat (HOLD_CYCLES) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_settings.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatches++;
			end else begin
				oldest = pending_settings.pop_front();
				check_field("bad_request", 16'(oldest.bad_request), 16'(rsp_ch.bad_request));
				check_field("ref_halved", 16'(oldest.ref_halved), 16'(rsp_ch.ref_halved));
				check_field("out_div_code", 16'(oldest.out_div_code), 16'(rsp_ch.out_div_code));
				check_field("int_div_word", 16'(oldest.int_div_word), 16'(rsp_ch.int_div_word));
				check_field("frac_disabled", 16'(oldest.frac_disabled),
					16'(rsp_ch.frac_disabled));
				check_field("sdm_word", oldest.sdm_word, rsp_ch.sdm_word);
				results_seen++;
				if (oldest.bad_request)
					zero_results++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		reg_setting_t rs;
		logic [TGT_W-1:0]  t;
		logic [FINE_W-1:0] f;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.target_freq_hz <= '0;
		req_ch.vco_fine_tune <= '0;
		send_idle = 33;
		rcv_idle = 88;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_item(DIR_ROWS[i].target, DIR_ROWS[i].fine, DIR_ROWS[i].typed ?
				DIR_ROWS[i].want : calc_divider_setting(DIR_ROWS[i].target, DIR_ROWS[i].fine));
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p < N_PHASES - 1) begin
				rs = PHASE_REGS[p];
			end else begin
				rs.ref_hz = $urandom_range(1, 100000000);
				rs.vmin = VLIM_W'($urandom_range(500000000, 32'd3000000000));
				rs.vmax = rs.vmin + VLIM_W'($urandom_range(0, 32'd3000000000));
				rs.pwr = $urandom_range(0, 3);
			end
			program_registers(rs);
			@(posedge clk);
			if (p < 2) begin
				send_idle = 33;
				rcv_idle = 88;
			end else if (p < 5) begin
				send_idle = 88;
				rcv_idle = 33;
			end else begin
				send_idle = 0;
				rcv_idle = 0;
			end
			if (p == 5)
				hold_pending = 1'b1;
			repeat (PHASE_ITEMS) begin
				t = pick_target();
				f = $urandom_range(0, 3);
				send_item(t, f, calc_divider_setting(t, f));
			end
			wait_drained();
		end

		repeat (END_CYCLES) @(posedge clk);
		$display("Sent %0d requests under %0d register settings; %0d results compared,",
			items_sent, settings_used, results_seen);
		$display("%0d of them zero-target rejections, %0d mismatches.", zero_results, mismatches);
		if (mismatches == 0 && pending_settings.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
